/* design/reserved_ring_unit_allocator_assert.svh */
// Assertion macros shared by the allocator checker.
`ifndef RESERVED_RING_UNIT_ALLOCATOR_ASSERT_SVH
`define RESERVED_RING_UNIT_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define RRUA_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rrua: same-cycle check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define RRUA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rrua: next-cycle check failed");

`endif

/* design/rrua_pkg.sv */
// Shared types and codes of the reserved ring unit allocator.
package rrua_pkg;

    localparam int CFG_W = 6;

    localparam logic [1:0] CMD_LOOKUP         = 2'd0;
    localparam logic [1:0] CMD_WRITE_RESERVED = 2'd1;
    localparam logic [1:0] CMD_CLEAR          = 2'd2;

    localparam logic REG_CAPACITY = 1'b0;
    localparam logic REG_RESERVED = 1'b1;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] object_id;
        logic [4:0]  slot_index;
        logic        clear_reserved_too;
    } rrua_req_t;

    typedef struct packed {
        logic [4:0] unit;
        logic       newly_bound;
        logic       bad_slot;
        logic [5:0] remaining;
        logic       is_full;
    } rrua_rsp_t;

endpackage

/* design/rrua_req_if.sv */
// Request channel: valid/ready handshake carrying one command.
interface rrua_req_if;
    import rrua_pkg::*;

    logic      valid;
    logic      ready;
    rrua_req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* design/rrua_rsp_if.sv */
// Response channel: valid/ready handshake carrying one result.
interface rrua_rsp_if;
    import rrua_pkg::*;

    logic      valid;
    logic      ready;
    rrua_rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* design/reserved_ring_unit_allocator.sv */
// Reserved ring unit allocator: slot table in a synchronous RAM, scanned one slot per cycle.
// Lookup: scans the first E slots for the key, E = head, or capacity when full; a miss
//   binds the key to the head slot, or to the slot after the reserved ones when full.
// Reserved write, clear and unused command: straight from idle to done, no scan.
// One transaction in flight; a finished result waits in the output register, and the block is
//   ready in the cycle after the load. Reset (rst_n low, async) empties slots via valid bits.
module reserved_ring_unit_allocator #(
    parameter int MAX_UNITS = 32,
    parameter int ID_WIDTH  = 32
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic                      cfg_index,
    input  logic [rrua_pkg::CFG_W-1:0] cfg_data,
    rrua_req_if.sink                  req,
    rrua_rsp_if.source                rsp
);
    import rrua_pkg::*;

    // Slot index width and the stored key width (IDs arrive as 32 bits).
    localparam int IDX_W = (MAX_UNITS > 1) ? $clog2(MAX_UNITS) : 1;
    localparam int KEY_W = (ID_WIDTH < 32) ? ID_WIDTH : 32;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    // Control state
    logic [1:0]           state_reg, state_next;
    logic [5:0]           cap_cfg_reg;
    logic [4:0]           res_cfg_reg;
    logic [5:0]           head_reg, head_next;
    logic                 full_reg, full_next;
    logic [MAX_UNITS-1:0] valid_reg, valid_next;
    logic [5:0]           issue_reg, issue_next;
    logic                 cmp_valid_reg, cmp_valid_next;
    logic                 rsp_valid_reg, rsp_valid_next;

    // Payload of the transaction in flight and of the held result
    logic [KEY_W-1:0]     key_reg, key_next;
    logic [5:0]           end_reg, end_next;
    logic [IDX_W-1:0]     cmp_idx_reg, cmp_idx_next;
    logic [IDX_W-1:0]     unit_reg, unit_next;
    logic                 newly_reg, newly_next;
    logic                 bad_reg, bad_next;
    rrua_rsp_t            rsp_data_reg, rsp_data_next;

    // Slot RAM: one write port, one read port with registered data
    logic [KEY_W-1:0]     slot_mem [MAX_UNITS];
    logic [KEY_W-1:0]     rd_data_reg;
    logic                 mem_we, mem_re;
    logic [IDX_W-1:0]     mem_waddr, mem_raddr;
    logic [KEY_W-1:0]     mem_wdata;

    // Effective configuration and helpers
    logic [5:0]           cap_eff, cap_m1, res_eff;
    logic [5:0]           head_adj, miss_base, head_inc, head_wrap, remaining;
    logic                 hit, issue_more, rsp_load;
    logic [KEY_W-1:0]     req_key;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= slot_mem[mem_raddr];
        end
    end

    // Clamp capacity to 1..MAX_UNITS and the reserved count below it.
    always_comb
    begin
        cap_eff = (cap_cfg_reg == 6'd0) ? 6'd1 : cap_cfg_reg;
        if (int'(cap_eff) > MAX_UNITS)
        begin
            cap_eff = 6'(MAX_UNITS);
        end
        cap_m1  = cap_eff - 6'd1;
        res_eff = ({1'b0, res_cfg_reg} > cap_m1) ? cap_m1 : {1'b0, res_cfg_reg};
    end

    assign req_key = req.data.object_id[KEY_W-1:0];

    // A lookup first pulls a stray head back to the first unreserved slot.
    assign head_adj = (!full_reg && (head_reg >= cap_eff || head_reg < res_eff)) ?
                      res_eff : head_reg;

    // A miss while full restarts the ring just after the reserved slots.
    assign miss_base = full_reg ? res_eff : head_reg;
    assign head_inc  = miss_base + 6'd1;
    assign head_wrap = (head_inc == cap_eff) ? 6'd0 : head_inc;

    assign hit        = cmp_valid_reg && valid_reg[cmp_idx_reg] && (rd_data_reg == key_reg);
    assign issue_more = issue_reg < end_reg;

    assign remaining  = (head_reg <= cap_eff) ? (cap_eff - head_reg) : 6'd0;

    assign req.ready  = (state_reg == S_IDLE);
    assign rsp.valid  = rsp_valid_reg;
    assign rsp.data   = rsp_data_reg;

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        full_next      = full_reg;
        valid_next     = valid_reg;
        issue_next     = issue_reg;
        cmp_valid_next = cmp_valid_reg;
        key_next       = key_reg;
        end_next       = end_reg;
        cmp_idx_next   = cmp_idx_reg;
        unit_next      = unit_reg;
        newly_next     = newly_reg;
        bad_next       = bad_reg;
        mem_we         = 1'b0;
        mem_waddr      = '0;
        mem_wdata      = key_reg;
        mem_re         = 1'b0;
        mem_raddr      = IDX_W'(issue_reg);
        rsp_load       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    unit_next  = '0;
                    newly_next = 1'b0;
                    bad_next   = 1'b0;
                    state_next = S_DONE;
                    case (req.data.cmd)
                        CMD_LOOKUP:
                        begin
                            head_next      = head_adj;
                            end_next       = full_reg ? cap_eff : head_adj;
                            issue_next     = 6'd0;
                            cmp_valid_next = 1'b0;
                            key_next       = req_key;
                            state_next     = S_SCAN;
                        end
                        CMD_WRITE_RESERVED:
                        begin
                            if ({1'b0, req.data.slot_index} < res_eff)
                            begin
                                mem_we                = 1'b1;
                                mem_waddr             = IDX_W'(req.data.slot_index);
                                mem_wdata             = req_key;
                                valid_next[mem_waddr] = 1'b1;
                            end
                            else
                            begin
                                bad_next = 1'b1;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            head_next = res_eff;
                            full_next = 1'b0;
                            for (int i = 0; i < MAX_UNITS; i++)
                            begin
                                if (req.data.clear_reserved_too || i >= int'(res_eff))
                                begin
                                    valid_next[i] = 1'b0;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (hit)
                begin
                    unit_next  = cmp_idx_reg;
                    state_next = S_DONE;
                end
                else if (issue_more)
                begin
                    mem_re         = 1'b1;
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = IDX_W'(issue_reg);
                    issue_next     = issue_reg + 6'd1;
                end
                else if (cmp_valid_reg)
                begin
                    // drain the last read before declaring a miss
                    cmp_valid_next = 1'b0;
                end
                else
                begin
                    mem_we                = 1'b1;
                    mem_waddr             = IDX_W'(miss_base);
                    valid_next[mem_waddr] = 1'b1;
                    unit_next             = IDX_W'(miss_base);
                    newly_next            = 1'b1;
                    head_next             = head_wrap;
                    full_next             = (head_wrap == 6'd0);
                    state_next            = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_data_next             = rsp_data_reg;
        rsp_valid_next            = rsp_valid_reg;
        if (rsp_load)
        begin
            rsp_valid_next            = 1'b1;
            rsp_data_next.unit        = 5'(unit_reg);
            rsp_data_next.newly_bound = newly_reg;
            rsp_data_next.bad_slot    = bad_reg;
            rsp_data_next.remaining   = remaining;
            rsp_data_next.is_full     = full_reg;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cap_cfg_reg   <= 6'd32;
            res_cfg_reg   <= 5'd0;
            head_reg      <= 6'd0;
            full_reg      <= 1'b0;
            valid_reg     <= '0;
            issue_reg     <= 6'd0;
            cmp_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            full_reg      <= full_next;
            valid_reg     <= valid_next;
            issue_reg     <= issue_next;
            cmp_valid_reg <= cmp_valid_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_CAPACITY: cap_cfg_reg <= cfg_data;
                    REG_RESERVED: res_cfg_reg <= cfg_data[4:0];
                    default:      cap_cfg_reg <= cap_cfg_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg      <= key_next;
        end_reg      <= end_next;
        cmp_idx_reg  <= cmp_idx_next;
        unit_reg     <= unit_next;
        newly_reg    <= newly_next;
        bad_reg      <= bad_next;
        rsp_data_reg <= rsp_data_next;
    end

endmodule

/* design/rrua_checker.sv */
// Port-level checker for the allocator and its bind.
module rrua_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               req_valid,
    input logic               req_ready,
    input logic               rsp_valid,
    input logic               rsp_ready,
    input rrua_pkg::rrua_rsp_t rsp_data
);
    import rrua_pkg::*;

`include "reserved_ring_unit_allocator_assert.svh"

    // hold a stalled result
    `RRUA_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))
    // one transaction at a time: busy right after acceptance
    `RRUA_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready)
    // a refused reserved write reports no unit and no binding
    `RRUA_ASSERT_SAME(a_bad_clean, rsp_valid && rsp_data.bad_slot, rsp_data.unit == 5'd0 && !rsp_data.newly_bound)
    // a full table has its head at slot zero, so the whole capacity remains
    `RRUA_ASSERT_SAME(a_full_remaining, rsp_valid && rsp_data.is_full, rsp_data.remaining != 6'd0)

endmodule

bind reserved_ring_unit_allocator rrua_checker u_rrua_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data)
);

/* test/tb_reserved_ring_unit_allocator.sv */
// Testbench for the reserved ring unit allocator: directed table, random traffic, scoreboard.
module tb_reserved_ring_unit_allocator;
    import rrua_pkg::*;

    localparam int SLOTS           = 32;
    localparam int SEGMENTS        = 25;
    localparam int SEGMENT_ITEMS   = 70;
    localparam int POOL_SIZE       = 24;
    localparam int DRAIN_CYCLES    = 40;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int CYCLE_LIMIT     = 800000;
    localparam int PRINT_LIMIT     = 40;

    // Command code that the block must treat as a no-op.
    localparam logic [1:0]  CMD_UNUSED  = 2'd3;
    localparam logic [31:0] ID_ALL_ONES = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {ROW_ITEM, ROW_TYPED, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t  kind;
        logic       cfg_reg;
        logic [5:0] cfg_val;
        rrua_req_t  req;
        rrua_rsp_t  rsp;
    } stim_row_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic               cfg_index;
    logic [CFG_W-1:0]   cfg_data;

    rrua_req_if req_ch ();
    rrua_rsp_if rsp_ch ();

    reserved_ring_unit_allocator #(
        .MAX_UNITS (SLOTS),
        .ID_WIDTH  (32)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    // Shadow copy of the allocator: slot contents, head, full flag and both registers.
    logic [31:0] slot_id   [SLOTS];
    bit          slot_live [SLOTS];
    int          head_slot;
    bit          table_full;
    logic [5:0]  capacity_reg;
    logic [4:0]  reserved_reg;

    rrua_rsp_t   unit_results_due [$];
    stim_row_t   directed_rows [$];
    logic [31:0] id_pool [POOL_SIZE];

    int mismatch_count;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_off_left;
    int cycle_count;

    // Clock: period of 2 time units.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Capacity register clamped to 1..SLOTS.
    function automatic int eff_capacity();
        int c;
        c = capacity_reg;
        if (c < 1)
            c = 1;
        if (c > SLOTS)
            c = SLOTS;
        return c;
    endfunction

    // Reserved count clamped below the effective capacity.
    function automatic int eff_reserved();
        int c;
        int r;
        c = eff_capacity();
        r = reserved_reg;
        if (r > c - 1)
            r = c - 1;
        return r;
    endfunction

    // Apply one command to the shadow table and return the result it must produce.
    function automatic rrua_rsp_t predict_unit_result(rrua_req_t r);
        int        cap;
        int        res;
        int        scan_end;
        bit        hit;
        rrua_rsp_t o;
        cap = eff_capacity();
        res = eff_reserved();
        o   = '0;
        hit = 1'b0;
        case (r.cmd)
            CMD_LOOKUP:
            begin
                // Pull a stray head back to the first unreserved slot (only while not full).
                if (!table_full && (head_slot >= cap || head_slot < res))
                    head_slot = res;
                // Search the filled part, or every slot in use once the table is full.
                scan_end = table_full ? cap : head_slot;
                for (int i = 0; i < scan_end; i++)
                begin
                    if (!hit && slot_live[i] && slot_id[i] == r.object_id)
                    begin
                        o.unit = 5'(i);
                        hit    = 1'b1;
                    end
                end
                if (!hit)
                begin
                    // A miss on a full table restarts the ring after the reserved slots.
                    if (table_full)
                    begin
                        head_slot  = res;
                        table_full = 1'b0;
                    end
                    slot_id[head_slot]   = r.object_id;
                    slot_live[head_slot] = 1'b1;
                    o.unit        = 5'(head_slot);
                    o.newly_bound = 1'b1;
                    head_slot     = (head_slot + 1) % cap;
                    if (head_slot == 0)
                        table_full = 1'b1;
                end
            end
            CMD_WRITE_RESERVED:
            begin
                if (r.slot_index < res)
                begin
                    slot_id[r.slot_index]   = r.object_id;
                    slot_live[r.slot_index] = 1'b1;
                end
                else
                    o.bad_slot = 1'b1;
            end
            CMD_CLEAR:
            begin
                head_slot  = res;
                table_full = 1'b0;
                for (int i = (r.clear_reserved_too ? 0 : res); i < SLOTS; i++)
                    slot_live[i] = 1'b0;
            end
            default:
            begin
                // Unused code: leave the table alone.
            end
        endcase
        o.remaining = (head_slot <= cap) ? 6'(cap - head_slot) : 6'd0;
        o.is_full   = table_full;
        return o;
    endfunction

    // Print one mismatch line (up to a limit) and count it.
    task automatic report_mismatch(string what, int got, int want);
        if (mismatch_count < PRINT_LIMIT)
            $display("[cycle %0d] %s: got %0d, want %0d", cycle_count, what, got, want);
        mismatch_count++;
    endtask

    // Compare a received result against the oldest pending expectation.
    task automatic check_unit_result(rrua_rsp_t got);
        rrua_rsp_t want;
        if (unit_results_due.size() == 0)
        begin
            report_mismatch("result with no transaction pending, unit", got.unit, 0);
            return;
        end
        want = unit_results_due.pop_front();
        if (got.unit !== want.unit)
            report_mismatch("unit", got.unit, want.unit);
        if (got.newly_bound !== want.newly_bound)
            report_mismatch("newly_bound", got.newly_bound, want.newly_bound);
        if (got.bad_slot !== want.bad_slot)
            report_mismatch("bad_slot", got.bad_slot, want.bad_slot);
        if (got.remaining !== want.remaining)
            report_mismatch("remaining", got.remaining, want.remaining);
        if (got.is_full !== want.is_full)
            report_mismatch("is_full", got.is_full, want.is_full);
    endtask

    // Append one line of the directed table.
    function automatic void add_row(row_kind_t kind, logic cfg_reg, logic [5:0] cfg_val,
                                    logic [1:0] cmd, logic [31:0] id, logic [4:0] slot,
                                    logic clr, logic [4:0] unit, logic nb, logic bad,
                                    logic [5:0] rem, logic full);
        stim_row_t row;
        row.kind                   = kind;
        row.cfg_reg                = cfg_reg;
        row.cfg_val                = cfg_val;
        row.req.cmd                = cmd;
        row.req.object_id          = id;
        row.req.slot_index         = slot;
        row.req.clear_reserved_too = clr;
        row.rsp.unit               = unit;
        row.rsp.newly_bound        = nb;
        row.rsp.bad_slot           = bad;
        row.rsp.remaining          = rem;
        row.rsp.is_full            = full;
        directed_rows.push_back(row);
    endfunction

    // Write one register at the next rising edge; the shadow copy follows at once,
    // which is safe because writes only happen with nothing in flight.
    task automatic write_register(logic idx, logic [5:0] val);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        if (idx == REG_CAPACITY)
            capacity_reg = val;
        else
            reserved_reg = val[4:0];
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // Drop valid and hold until every pending result has come back.
    task automatic wait_idle();
        req_ch.valid = 1'b0;
        while (unit_results_due.size() != 0)
            @(negedge clk);
    endtask

    // Offer one transaction after a random gap; predict it on acceptance.
    // Called at a falling edge, returns at a falling edge with valid still high.
    task automatic send_item(rrua_req_t r, bit typed, rrua_rsp_t typed_rsp);
        rrua_rsp_t predicted;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_ch.valid = 1'b0;
            @(negedge clk);
        end
        req_ch.valid = 1'b1;
        req_ch.data  = r;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        predicted = predict_unit_result(r);
        unit_results_due.push_back(typed ? typed_rsp : predicted);
        @(negedge clk);
    endtask

    // Result side: random back-pressure, or a long hold-off when one is requested.
    initial
    begin
        rsp_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_off_left > 0)
            begin
                rsp_ch.ready = 1'b0;
                hold_off_left--;
            end
            else
                rsp_ch.ready = ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Scoreboard: sample each result transaction at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            check_unit_result(rsp_ch.data);
    end

    // Watchdog: end the run if it stalls past the cycle budget.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Mismatches found");
        $finish;
    end

    // Stimulus: directed table first, then random segments with a fresh setting each.
    initial
    begin
        rrua_req_t r;
        int        pick;
        int        c;
        int        res_max;

        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = REG_CAPACITY;
        cfg_data       = '0;
        req_ch.valid   = 1'b0;
        req_ch.data    = '0;
        mismatch_count = 0;
        hold_off_left  = 0;
        send_idle_pct  = 21;
        recv_idle_pct  = 48;

        // Shadow state after reset: all slots empty, capacity 32, nothing reserved.
        capacity_reg = 6'd32;
        reserved_reg = 5'd0;
        head_slot    = 0;
        table_full   = 1'b0;
        foreach (slot_live[i])
        begin
            slot_live[i] = 1'b0;
            slot_id[i]   = '0;
        end

        // Directed table. Typed expectations only where the answer is obvious; the rest
        // goes through the predictor.
        //      kind       reg           val    cmd                 id             slot  clr
        //                                                          unit nb bad rem  full
        add_row(ROW_TYPED, REG_CAPACITY, 6'd0,  CMD_LOOKUP,         32'h0,         5'd0, 1'b0,
                5'd0, 1'b1, 1'b0, 6'd31, 1'b0);
        add_row(ROW_TYPED, REG_CAPACITY, 6'd0,  CMD_LOOKUP,         32'h0,         5'd0, 1'b0,
                5'd0, 1'b0, 1'b0, 6'd31, 1'b0);
        // An all-ones ID must not match an empty slot.
        add_row(ROW_TYPED, REG_CAPACITY, 6'd0,  CMD_LOOKUP,         ID_ALL_ONES,   5'd0, 1'b0,
                5'd1, 1'b1, 1'b0, 6'd30, 1'b0);
        add_row(ROW_TYPED, REG_CAPACITY, 6'd0,  CMD_LOOKUP,         ID_ALL_ONES,   5'd0, 1'b0,
                5'd1, 1'b0, 1'b0, 6'd30, 1'b0);
        // Reserved write with nothing reserved is refused.
        add_row(ROW_TYPED, REG_CAPACITY, 6'd0,  CMD_WRITE_RESERVED, 32'h5,         5'd0, 1'b0,
                5'd0, 1'b0, 1'b1, 6'd30, 1'b0);
        add_row(ROW_TYPED, REG_CAPACITY, 6'd0,  CMD_UNUSED,         ID_ALL_ONES,   5'd31, 1'b1,
                5'd0, 1'b0, 1'b0, 6'd30, 1'b0);
        add_row(ROW_TYPED, REG_CAPACITY, 6'd0,  CMD_CLEAR,          32'h0,         5'd0, 1'b0,
                5'd0, 1'b0, 1'b0, 6'd32, 1'b0);
        add_row(ROW_TYPED, REG_CAPACITY, 6'd0,  CMD_LOOKUP,         32'h0,         5'd0, 1'b0,
                5'd0, 1'b1, 1'b0, 6'd31, 1'b0);
        // Two slots, one reserved: exercise wrap, full search and miss while full.
        add_row(ROW_CFG,   REG_CAPACITY, 6'd2,  CMD_LOOKUP,         32'h0,         5'd0, 1'b0,
                5'd0, 1'b0, 1'b0, 6'd0,  1'b0);
        add_row(ROW_CFG,   REG_RESERVED, 6'd1,  CMD_LOOKUP,         32'h0,         5'd0, 1'b0,
                5'd0, 1'b0, 1'b0, 6'd0,  1'b0);
        add_row(ROW_ITEM,  REG_CAPACITY, 6'd0,  CMD_WRITE_RESERVED, 32'hA5A5_A5A5, 5'd0, 1'b0,
                5'd0, 1'b0, 1'b0, 6'd0,  1'b0);
        add_row(ROW_TYPED, REG_CAPACITY, 6'd0,  CMD_WRITE_RESERVED, 32'h1,         5'd31, 1'b0,
                5'd0, 1'b0, 1'b1, 6'd1,  1'b0);
        add_row(ROW_ITEM,  REG_CAPACITY, 6'd0,  CMD_LOOKUP,         32'hA5A5_A5A5, 5'd0, 1'b0,
                5'd0, 1'b0, 1'b0, 6'd0,  1'b0);
        add_row(ROW_ITEM,  REG_CAPACITY, 6'd0,  CMD_LOOKUP,         32'h7,         5'd0, 1'b0,
                5'd0, 1'b0, 1'b0, 6'd0,  1'b0);
        add_row(ROW_ITEM,  REG_CAPACITY, 6'd0,  CMD_LOOKUP,         32'h7,         5'd0, 1'b0,
                5'd0, 1'b0, 1'b0, 6'd0,  1'b0);
        add_row(ROW_ITEM,  REG_CAPACITY, 6'd0,  CMD_LOOKUP,         32'h9,         5'd0, 1'b0,
                5'd0, 1'b0, 1'b0, 6'd0,  1'b0);
        add_row(ROW_ITEM,  REG_CAPACITY, 6'd0,  CMD_CLEAR,          32'h0,         5'd0, 1'b1,
                5'd0, 1'b0, 1'b0, 6'd0,  1'b0);
        add_row(ROW_ITEM,  REG_CAPACITY, 6'd0,  CMD_LOOKUP,         32'hA5A5_A5A5, 5'd0, 1'b0,
                5'd0, 1'b0, 1'b0, 6'd0,  1'b0);
        // Capacity zero clamps to one slot; reserved count clamps to zero.
        add_row(ROW_CFG,   REG_CAPACITY, 6'd0,  CMD_LOOKUP,         32'h0,         5'd0, 1'b0,
                5'd0, 1'b0, 1'b0, 6'd0,  1'b0);
        add_row(ROW_CFG,   REG_RESERVED, 6'd31, CMD_LOOKUP,         32'h0,         5'd0, 1'b0,
                5'd0, 1'b0, 1'b0, 6'd0,  1'b0);
        add_row(ROW_ITEM,  REG_CAPACITY, 6'd0,  CMD_LOOKUP,         32'h1234,      5'd0, 1'b0,
                5'd0, 1'b0, 1'b0, 6'd0,  1'b0);
        add_row(ROW_TYPED, REG_CAPACITY, 6'd0,  CMD_WRITE_RESERVED, 32'h2,         5'd0, 1'b0,
                5'd0, 1'b0, 1'b1, 6'd1,  1'b1);
        // Capacity beyond the table clamps to all slots, with 31 reserved.
        add_row(ROW_CFG,   REG_CAPACITY, 6'd63, CMD_LOOKUP,         32'h0,         5'd0, 1'b0,
                5'd0, 1'b0, 1'b0, 6'd0,  1'b0);
        add_row(ROW_CFG,   REG_RESERVED, 6'd31, CMD_LOOKUP,         32'h0,         5'd0, 1'b0,
                5'd0, 1'b0, 1'b0, 6'd0,  1'b0);
        add_row(ROW_ITEM,  REG_CAPACITY, 6'd0,  CMD_LOOKUP,         32'h0,         5'd0, 1'b0,
                5'd0, 1'b0, 1'b0, 6'd0,  1'b0);
        add_row(ROW_ITEM,  REG_CAPACITY, 6'd0,  CMD_WRITE_RESERVED, ID_ALL_ONES,   5'd30, 1'b0,
                5'd0, 1'b0, 1'b0, 6'd0,  1'b0);
        add_row(ROW_ITEM,  REG_CAPACITY, 6'd0,  CMD_LOOKUP,         ID_ALL_ONES,   5'd0, 1'b0,
                5'd0, 1'b0, 1'b0, 6'd0,  1'b0);
        add_row(ROW_ITEM,  REG_CAPACITY, 6'd0,  CMD_CLEAR,          32'h0,         5'd0, 1'b0,
                5'd0, 1'b0, 1'b0, 6'd0,  1'b0);
        // Shrink capacity under the head: remaining reads zero, the next lookup
        // pulls the head back to the first unreserved slot.
        add_row(ROW_CFG,   REG_CAPACITY, 6'd4,  CMD_LOOKUP,         32'h0,         5'd0, 1'b0,
                5'd0, 1'b0, 1'b0, 6'd0,  1'b0);
        add_row(ROW_CFG,   REG_RESERVED, 6'd2,  CMD_LOOKUP,         32'h0,         5'd0, 1'b0,
                5'd0, 1'b0, 1'b0, 6'd0,  1'b0);
        add_row(ROW_TYPED, REG_CAPACITY, 6'd0,  CMD_UNUSED,         32'h0,         5'd0, 1'b0,
                5'd0, 1'b0, 1'b0, 6'd0,  1'b0);
        add_row(ROW_ITEM,  REG_CAPACITY, 6'd0,  CMD_LOOKUP,         32'h77,        5'd0, 1'b0,
                5'd0, 1'b0, 1'b0, 6'd0,  1'b0);

        // Hold reset, then release it at a falling edge.
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Walk the directed table; register writes wait for the block to drain.
        foreach (directed_rows[k])
        begin
            if (directed_rows[k].kind == ROW_CFG)
            begin
                wait_idle();
                write_register(directed_rows[k].cfg_reg, directed_rows[k].cfg_val);
            end
            else
                send_item(directed_rows[k].req, directed_rows[k].kind == ROW_TYPED,
                          directed_rows[k].rsp);
        end

        // Random segments: each starts idle with a new setting and a new ID pool.
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            wait_idle();

            // Swap the idle pattern a third of the way in, then drop idling altogether.
            if (seg == 9)
            begin
                send_idle_pct = 48;
                recv_idle_pct = 21;
            end
            else if (seg == 17)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            // Capacity: favor the extremes, sometimes out of range to hit the clamp.
            pick = $urandom_range(0, 9);
            case (pick)
                0:       c = 1;
                1:       c = 2;
                2:       c = SLOTS;
                3:       c = 0;
                4:       c = $urandom_range(33, 63);
                default: c = $urandom_range(1, SLOTS);
            endcase
            write_register(REG_CAPACITY, 6'(c));
            res_max = eff_capacity() - 1;
            pick = $urandom_range(0, 9);
            case (pick)
                0:       c = 0;
                1:       c = res_max;
                2:       c = 31;
                default: c = $urandom_range(0, 31);
            endcase
            write_register(REG_RESERVED, 6'(c));

            // A small pool of IDs makes repeat lookups hit; all-zero and all-ones show up.
            foreach (id_pool[i])
            begin
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    id_pool[i] = '0;
                else if (pick == 1)
                    id_pool[i] = ID_ALL_ONES;
                else
                    id_pool[i] = $urandom;
            end

            // Stall results for a long stretch so the block fills and backs up its input.
            if (seg == 0 || seg == 17)
                hold_off_left = HOLD_OFF_CYCLES;

            for (int n = 0; n < SEGMENT_ITEMS; n++)
            begin
                r.object_id          = ($urandom_range(0, 99) < 85) ?
                                       id_pool[$urandom_range(0, POOL_SIZE - 1)] : $urandom;
                r.slot_index         = 5'($urandom_range(0, 31));
                r.clear_reserved_too = 1'($urandom_range(0, 1));
                pick = $urandom_range(0, 99);
                if (pick < 77)
                    r.cmd = CMD_LOOKUP;
                else if (pick < 92)
                begin
                    r.cmd = CMD_WRITE_RESERVED;
                    // Mostly legal reserved slots, the rest anywhere.
                    if (eff_reserved() > 0 && $urandom_range(0, 4) != 0)
                        r.slot_index = 5'($urandom_range(0, eff_reserved() - 1));
                end
                else if (pick < 97)
                    r.cmd = CMD_CLEAR;
                else
                    r.cmd = CMD_UNUSED;
                send_item(r, 1'b0, '0);
            end
        end

        // Drain, then give stray results a chance to show up.
        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+design
design/rrua_pkg.sv
design/rrua_req_if.sv
design/rrua_rsp_if.sv
design/reserved_ring_unit_allocator.sv
design/rrua_checker.sv
test/tb_reserved_ring_unit_allocator.sv
